@@ hdl/shuffled_combined_lcg_generator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Shuffled combined LCG generator: assertion macros
// Immediate-implication and next-cycle-implication checks on the core clock.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_COMBINED_LCG_GENERATOR_CORE_MACROS_SVH
`define SHUFFLED_COMBINED_LCG_GENERATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCLG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SCLG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCLG_ASSERT_IMP(lbl, ante, cons, msg)
`define SCLG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/sclg_pkg.sv @@
// ----------------------------------------------------------------------------
// Shuffled combined LCG generator: package
// Constants, control word layout and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sclg_pkg;

  localparam int unsigned RAW_W  = 31;
  localparam int unsigned FRAC_W = 32;
  localparam int unsigned MUL_W  = 16;

  localparam int TABLE_SIZE_DEF = 32;
  localparam int WARMUP         = 8;

  localparam logic [31:0] MOD1 = 32'd2147483563;
  localparam logic [31:0] MOD2 = 32'd2147483399;
  localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
  localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

  // The moduli sit just below 2^31, so 2^31 folds back as these small offsets.
  localparam logic [7:0] FOLD1 = 8'(32'h8000_0000 - MOD1);
  localparam logic [7:0] FOLD2 = 8'(32'h8000_0000 - MOD2);
  localparam logic [7:0] FRAC_K = 8'(2 * FOLD1);

  localparam logic [FRAC_W-1:0] FRACTION_MAX = 32'd4294966780;
  localparam logic [RAW_W-1:0]  SEED2_RESET  = 31'd123456789;

  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_W_A  = 4'd1;
  localparam logic [PC_W-1:0] PC_W_B  = 4'd2;
  localparam logic [PC_W-1:0] PC_W_C  = 4'd3;
  localparam logic [PC_W-1:0] PC_D_A  = 4'd4;
  localparam logic [PC_W-1:0] PC_D_B  = 4'd5;
  localparam logic [PC_W-1:0] PC_D_C  = 4'd6;
  localparam logic [PC_W-1:0] PC_D_D  = 4'd7;
  localparam logic [PC_W-1:0] PC_D_E  = 4'd8;
  localparam logic [PC_W-1:0] PC_D_F  = 4'd9;
  localparam logic [PC_W-1:0] PC_D_G  = 4'd10;
  localparam logic [PC_W-1:0] PC_D_H  = 4'd11;
  localparam logic [PC_W-1:0] PC_D_I  = 4'd12;
  localparam logic [PC_W-1:0] PC_D_J  = 4'd13;

  localparam logic [1:0] JMP_NEXT     = 2'd0;
  localparam logic [1:0] JMP_DISPATCH = 2'd1;
  localparam logic [1:0] JMP_LOOP     = 2'd2;
  localparam logic [1:0] JMP_ALWAYS   = 2'd3;

  typedef struct packed {
    logic            mul_en;
    logic            red_en;
    logic            st_wr;
    logic            gen;
    logic            idx_est;
    logic            idx_fix;
    logic            mem_rd;
    logic            mem_wr;
    logic            fill;
    logic            diff_en;
    logic            frac_mul;
    logic            frac_fix;
    logic            out_ld;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      PC_IDLE: w.jmp = JMP_DISPATCH;
      PC_W_A:  w.mul_en = 1'b1;
      PC_W_B:  w.red_en = 1'b1;
      PC_W_C: begin
        w.st_wr  = 1'b1;
        w.fill   = 1'b1;
        w.jmp    = JMP_LOOP;
        w.target = PC_W_A;
      end
      PC_D_A: begin
        w.mul_en  = 1'b1;
        w.idx_est = 1'b1;
      end
      PC_D_B: begin
        w.red_en  = 1'b1;
        w.idx_fix = 1'b1;
      end
      PC_D_C: begin
        w.st_wr  = 1'b1;
        w.mem_rd = 1'b1;
      end
      PC_D_D: begin
        w.mul_en = 1'b1;
        w.gen    = 1'b1;
        w.mem_wr = 1'b1;
      end
      PC_D_E: begin
        w.red_en = 1'b1;
        w.gen    = 1'b1;
      end
      PC_D_F: begin
        w.st_wr = 1'b1;
        w.gen   = 1'b1;
      end
      PC_D_G: w.diff_en  = 1'b1;
      PC_D_H: w.frac_mul = 1'b1;
      PC_D_I: w.frac_fix = 1'b1;
      PC_D_J: begin
        w.out_ld = 1'b1;
        w.jmp    = JMP_ALWAYS;
        w.target = PC_IDLE;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sclg_if.sv @@
// ----------------------------------------------------------------------------
// Shuffled combined LCG generator: channel interfaces
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sclg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [sclg_pkg::RAW_W-1:0]  seed_value;

  modport source (output valid, func, seed_value, input ready);
  modport sink   (input valid, func, seed_value, output ready);
endinterface

interface sclg_out_if;
  logic                        valid;
  logic                        ready;
  logic [sclg_pkg::RAW_W-1:0]  raw_value;
  logic [sclg_pkg::FRAC_W-1:0] fraction;

  modport source (output valid, raw_value, fraction, input ready);
  modport sink   (input valid, raw_value, fraction, output ready);
endinterface

`default_nettype wire

@@ hdl/shuffled_combined_lcg_generator_core.sv @@
// ----------------------------------------------------------------------------
// Shuffled combined LCG generator core
// Two multiplicative congruential generators mixed through a shuffle table,
// run by a microcoded sequencer over one shared multiply-and-fold datapath.
// ----------------------------------------------------------------------------
//   channel   direction  payload                  handshake
//   in_ch     sink       func, seed_value         valid / ready
//   out_ch    source     raw_value, fraction      valid / ready
//
// A draw steps through the states PC_D_A to PC_D_J and loads the result
// register in PC_D_J; the sequencer then returns to idle, where the next transaction is taken.
// A reseed, or a draw while unseeded, first runs TABLE_SIZE + 8 warm-up steps,
// each through the states PC_W_A, PC_W_B and PC_W_C of the shared multiply and
// modulus fold unit, and then goes on to the draw.
// Reset is synchronous; the core is idle and unseeded after it.
// The last step waits while an earlier result has not been taken.
`default_nettype none

`include "shuffled_combined_lcg_generator_core_macros.svh"

module shuffled_combined_lcg_generator_core #(
  parameter int TABLE_SIZE = sclg_pkg::TABLE_SIZE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sclg_in_if.sink     in_ch,
  sclg_out_if.source  out_ch
);

  localparam int RAW_W  = sclg_pkg::RAW_W;
  localparam int FRAC_W = sclg_pkg::FRAC_W;
  localparam int PC_W   = sclg_pkg::PC_W;
  localparam int WARM   = sclg_pkg::WARMUP;
  localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W  = $clog2(TABLE_SIZE + WARM);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE + WARM - 1);
  localparam logic [CNT_W-1:0] CNT_WARM = CNT_W'(WARM);

  localparam logic [63:0] IDX_DIV64 =
    64'd1 + (64'(sclg_pkg::MOD1) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [63:0] IDX_REC64 = (64'd1 << 31) / IDX_DIV64;
  localparam int REC_W = $clog2(IDX_REC64 + 1);
  localparam int EST_W = REC_W + 1;
  localparam logic [RAW_W-1:0]       IDX_DIV = RAW_W'(IDX_DIV64);
  localparam logic [REC_W-1:0]       IDX_REC = REC_W'(IDX_REC64);
  localparam logic [EST_W-1:0]       IDX_MAX = EST_W'(TABLE_SIZE - 1);
  localparam logic [RAW_W-1:0]       RAW_MAX = RAW_W'(sclg_pkg::MOD1 - 32'd1);

  sclg_pkg::uword_t uw;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAW_W-1:0] s1_r, s1_nxt;
  logic [RAW_W-1:0] s2_r, s2_nxt;
  logic [RAW_W-1:0] last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [RAW_W+sclg_pkg::MUL_W-1:0] p_r, p_nxt;
  logic [31:0]            y_r, y_nxt;
  logic [REC_W-1:0]       ie_r;
  logic [IDX_W-1:0]       idx_r;
  logic [RAW_W-1:0]       rd_r;
  logic [38:0]            fy_r, fy_nxt;
  logic [7:0]             fq_r;
  logic [31:0]            frr_r, frr_nxt;
  logic [RAW_W-1:0]       out_raw_r;
  logic [FRAC_W-1:0]      out_frac_r, frac_nxt;

  logic [RAW_W-1:0] tbl_mem [TABLE_SIZE];

  logic                    accept, seed_go, hold, out_go, at_last;
  logic [RAW_W-1:0]        seed_c, s_op, red_c, diff_c;
  logic [sclg_pkg::MUL_W-1:0] mul_c;
  logic [7:0]              fold_c;
  logic [31:0]             mod_c;
  logic [23:0]             hd_c;
  logic [RAW_W+REC_W-1:0]  ie_prod, idiv_c, irem_c;
  logic [EST_W-1:0]        isum_c, iclamp_c;
  logic [32:0]             dsub_c, dadj_c;
  logic [14:0]             fqd_c;
  logic [8:0]              fqs_c;
  logic [32:0]             fsum_c;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa, fill_idx;
  logic [RAW_W-1:0]        mem_wd;

  assign uw = sclg_pkg::ucode(pc_r);

  assign in_ch.ready      = (pc_r == sclg_pkg::PC_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign seed_go          = in_ch.func || (s1_r == '0);
  assign seed_c           = (in_ch.func && (in_ch.seed_value != '0)) ?
                            in_ch.seed_value : RAW_W'(1);
  assign at_last          = (cnt_r == CNT_LAST);
  assign hold             = uw.out_ld && out_valid_r && !out_ch.ready;
  assign out_go           = uw.out_ld && !hold;

  // Shared generator step: (mul * x) mod m, folding 2^31 back as 2^31 - m.
  assign s_op   = uw.gen ? s2_r : s1_r;
  assign mul_c  = uw.gen ? sclg_pkg::MUL2 : sclg_pkg::MUL1;
  assign fold_c = uw.gen ? sclg_pkg::FOLD2 : sclg_pkg::FOLD1;
  assign mod_c  = uw.gen ? sclg_pkg::MOD2 : sclg_pkg::MOD1;
  assign p_nxt  = s_op * mul_c;
  assign hd_c   = p_r[RAW_W+sclg_pkg::MUL_W-1:RAW_W] * fold_c;
  assign y_nxt  = {1'b0, p_r[RAW_W-1:0]} + {8'd0, hd_c};
  assign red_c  = (y_r >= mod_c) ? RAW_W'(y_r - mod_c) : y_r[RAW_W-1:0];

  // Table index: last output over the bucket width, by reciprocal and one fix.
  assign ie_prod  = last_r * IDX_REC;
  assign idiv_c   = ie_r * IDX_DIV;
  assign irem_c   = {{REC_W{1'b0}}, last_r} - idiv_c;
  assign isum_c   = {1'b0, ie_r} + EST_W'(irem_c >= {{REC_W{1'b0}}, IDX_DIV});
  assign iclamp_c = (isum_c > IDX_MAX) ? IDX_MAX : isum_c;

  assign dsub_c = {2'b00, rd_r} - {2'b00, s2_r};
  assign dadj_c = (dsub_c[32] || (dsub_c == '0)) ?
                  dsub_c + 33'(sclg_pkg::MOD1 - 32'd1) : dsub_c;
  assign diff_c = dadj_c[RAW_W-1:0];

  // Fraction: 2v + floor(2 * fold * v / m), since 2^32 = 2 * (m + fold).
  assign fy_nxt   = last_r * sclg_pkg::FRAC_K;
  assign fqd_c    = fy_r[38:31] * sclg_pkg::FOLD1;
  assign frr_nxt  = {1'b0, fy_r[30:0]} + {17'd0, fqd_c};
  assign fqs_c    = {1'b0, fq_r} + 9'(frr_r >= sclg_pkg::MOD1);
  assign fsum_c   = {1'b0, last_r, 1'b0} + {24'd0, fqs_c};
  assign frac_nxt = (fsum_c > {1'b0, sclg_pkg::FRACTION_MAX}) ?
                    sclg_pkg::FRACTION_MAX : fsum_c[FRAC_W-1:0];

  assign fill_idx = IDX_W'(CNT_LAST - cnt_r);
  assign mem_we   = (uw.fill && (cnt_r >= CNT_WARM)) || uw.mem_wr;
  assign mem_wa   = uw.fill ? fill_idx : idx_r;
  assign mem_wd   = uw.fill ? red_c : s1_r;

  always_comb begin
    pc_nxt = pc_r;
    unique case (uw.jmp)
      sclg_pkg::JMP_NEXT: pc_nxt = pc_r + PC_W'(1);
      sclg_pkg::JMP_DISPATCH: begin
        if (accept) begin
          pc_nxt = seed_go ? sclg_pkg::PC_W_A : sclg_pkg::PC_D_A;
        end
      end
      sclg_pkg::JMP_LOOP: pc_nxt = at_last ? pc_r + PC_W'(1) : uw.target;
      sclg_pkg::JMP_ALWAYS: pc_nxt = uw.target;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    last_nxt = last_r;
    if (accept && seed_go) begin
      cnt_nxt = '0;
      s1_nxt  = seed_c;
      s2_nxt  = seed_c;
    end
    if (uw.fill && !at_last) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (uw.st_wr && !uw.gen) begin
      s1_nxt = red_c;
    end
    if (uw.st_wr && uw.gen) begin
      s2_nxt = red_c;
    end
    if (uw.fill && at_last) begin
      last_nxt = red_c;
    end
    if (uw.diff_en) begin
      last_nxt = diff_c;
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= sclg_pkg::PC_IDLE;
      cnt_r       <= '0;
      s1_r        <= '0;
      s2_r        <= sclg_pkg::SEED2_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.mul_en) begin
      p_r <= p_nxt;
    end
    if (uw.red_en) begin
      y_r <= y_nxt;
    end
    if (uw.idx_est) begin
      ie_r <= ie_prod[RAW_W+REC_W-1:RAW_W];
    end
    if (uw.idx_fix) begin
      idx_r <= iclamp_c[IDX_W-1:0];
    end
    if (uw.frac_mul) begin
      fy_r <= fy_nxt;
    end
    if (uw.frac_fix) begin
      fq_r  <= fy_r[38:31];
      frr_r <= frr_nxt;
    end
    if (out_go) begin
      out_raw_r  <= last_r;
      out_frac_r <= frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (uw.mem_rd) begin
      rd_r <= tbl_mem[idx_r];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.raw_value = out_raw_r;
  assign out_ch.fraction  = out_frac_r;

  `SCLG_ASSERT_NXT(a_accept_starts, in_ch.valid && in_ch.ready, pc_r != sclg_pkg::PC_IDLE, "accepted transaction did not start the sequence")
  `SCLG_ASSERT_IMP(a_first_reduced, pc_r == sclg_pkg::PC_D_D, 32'(s1_r) < sclg_pkg::MOD1, "first generator state not reduced below its modulus")
  `SCLG_ASSERT_IMP(a_raw_range, out_valid_r, (out_raw_r != '0) && (out_raw_r <= RAW_MAX), "result integer outside its range")

endmodule

`default_nettype wire
